### rtl/fpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpr_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;

  // Largest frame in bytes, start and end markers included.
  localparam byte_t FrameBytes  = 8'd128;
  // Start marker, type, two length bytes and two CRC bytes.
  localparam byte_t HeaderBytes = 8'd6;

  localparam word_t CrcPoly = 16'h1021;
  localparam word_t CrcInit = 16'hFFFF;

  // Byte offsets of the header fields within a frame.
  localparam byte_t OffType  = 8'd1;
  localparam byte_t OffLenHi = 8'd2;
  localparam byte_t OffLenLo = 8'd3;
  localparam byte_t OffCrcHi = 8'd4;
  localparam byte_t OffCrcLo = 8'd5;

  localparam int unsigned CfgIdxW = 4;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CfgStartMarker = cfg_idx_t'(0);
  localparam cfg_idx_t CfgEndMarker   = cfg_idx_t'(1);

  localparam byte_t StartMarkerRst = 8'd2;
  localparam byte_t EndMarkerRst   = 8'd3;

  typedef enum logic [2:0] {
    ST_VALID        = 3'd0,
    ST_TOO_SHORT    = 3'd1,
    ST_LEN_MISMATCH = 3'd2,
    ST_CRC_MISMATCH = 3'd3,
    ST_OVERFLOW     = 3'd4
  } fpr_status_e;

  typedef struct packed {
    byte_t start_marker;
    byte_t end_marker;
  } fpr_markers_t;

  typedef struct packed {
    fpr_status_e frame_status;
    byte_t       message_type;
    word_t       payload_length;
    word_t       received_crc;
    word_t       computed_crc;
    byte_t       first_payload_byte;
  } fpr_result_t;

  // CRC-16-CCITT, MSB first, one byte per call.
  function automatic word_t crc16_byte(input word_t crc, input byte_t b);
    word_t c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/fpr_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface fpr_byte_if;
  import fpr_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpr_cfg_if;
  import fpr_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  byte_t    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface fpr_result_if;
  import fpr_pkg::*;
  logic       valid;
  logic       ready;
  logic [2:0] frame_status;
  byte_t      message_type;
  word_t      payload_length;
  word_t      received_crc;
  word_t      computed_crc;
  byte_t      first_payload_byte;
  modport source (output valid, output frame_status, output message_type,
                  output payload_length, output received_crc, output computed_crc,
                  output first_payload_byte, input ready);
  modport sink   (input valid, input frame_status, input message_type,
                  input payload_length, input received_crc, input computed_crc,
                  input first_payload_byte, output ready);
endinterface

`default_nettype wire

### rtl/fpr_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module fpr_cfg_regs (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  fpr_cfg_if.sink              cfg_i,
  output fpr_pkg::fpr_markers_t markers_o
);
  import fpr_pkg::*;

  fpr_markers_t markers_q;

  assign cfg_i.ready = 1'b1;
  assign markers_o   = markers_q;

  // Writes to indexes beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      markers_q.start_marker <= StartMarkerRst;
      markers_q.end_marker   <= EndMarkerRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgStartMarker: markers_q.start_marker <= cfg_i.data;
        CfgEndMarker:   markers_q.end_marker   <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/fpr_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module fpr_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire fpr_pkg::byte_t   rx_byte_i,
  input  wire fpr_pkg::fpr_markers_t markers_i,
  output logic                  emit_o,
  output fpr_pkg::fpr_result_t  result_o
);
  import fpr_pkg::*;

  logic  in_frame_q, in_frame_d;
  byte_t count_q, count_d;
  byte_t type_q, type_d;
  word_t len_q, len_d;
  word_t crc_rx_q, crc_rx_d;
  word_t crc_q, crc_d;
  byte_t first_q, first_d;

  logic [16:0] total_exp;
  fpr_status_e status;

  always_comb begin
    in_frame_d = in_frame_q;
    count_d    = count_q;
    type_d     = type_q;
    len_d      = len_q;
    crc_rx_d   = crc_rx_q;
    crc_d      = crc_q;
    first_d    = first_q;
    emit_o     = 1'b0;
    status     = ST_VALID;
    total_exp  = 17'(HeaderBytes) + 17'd1 + {1'b0, len_q};

    if (!in_frame_q) begin
      if (rx_byte_i == markers_i.start_marker) begin
        in_frame_d = 1'b1;
        count_d    = 8'd1;
        type_d     = '0;
        len_d      = '0;
        crc_rx_d   = '0;
        crc_d      = CrcInit;
        first_d    = '0;
      end
    end else if (count_q >= FrameBytes) begin
      // The byte that would overrun the frame is dropped.
      in_frame_d = 1'b0;
      emit_o     = 1'b1;
      status     = ST_OVERFLOW;
    end else begin
      count_d = count_q + 8'd1;
      case (count_q)
        OffType:  type_d   = rx_byte_i;
        OffLenHi: len_d    = {rx_byte_i, len_q[7:0]};
        OffLenLo: len_d    = {len_q[15:8], rx_byte_i};
        OffCrcHi: crc_rx_d = {rx_byte_i, crc_rx_q[7:0]};
        OffCrcLo: crc_rx_d = {crc_rx_q[15:8], rx_byte_i};
        default: ;
      endcase
      total_exp = 17'(HeaderBytes) + 17'd1 + {1'b0, len_d};

      if (rx_byte_i == markers_i.end_marker) begin
        // A header byte equal to the end marker is captured and also closes.
        in_frame_d = 1'b0;
        emit_o     = 1'b1;
        if (count_d < HeaderBytes) begin
          status = ST_TOO_SHORT;
        end else if ({9'd0, count_d} != total_exp) begin
          status = ST_LEN_MISMATCH;
        end else if (crc_rx_d != crc_q) begin
          status = ST_CRC_MISMATCH;
        end else begin
          status = ST_VALID;
        end
      end else if (count_q >= HeaderBytes) begin
        if (count_q == HeaderBytes) begin
          first_d = rx_byte_i;
        end
        crc_d = crc16_byte(crc_q, rx_byte_i);
      end
    end
  end

  always_comb begin
    result_o.frame_status       = status;
    result_o.message_type       = type_d;
    result_o.payload_length     = len_d;
    result_o.received_crc       = crc_rx_d;
    result_o.computed_crc       = crc_q;
    result_o.first_payload_byte = first_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= '0;
      type_q     <= '0;
      len_q      <= '0;
      crc_rx_q   <= '0;
      crc_q      <= CrcInit;
      first_q    <= '0;
    end else if (step_i) begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
      type_q     <= type_d;
      len_q      <= len_d;
      crc_rx_q   <= crc_rx_d;
      crc_q      <= crc_d;
      first_q    <= first_d;
    end
  end

endmodule

`default_nettype wire

### rtl/framed_packet_receiver_crc16.sv
// A result is registered when the parser consumes the closing byte. Throughput: one
// byte per cycle while the consumer keeps ready high; the byte register and the result
// register are each one entry deep, and the combinational CRC update sets the pace.
// Reset (rst_ni, asynchronous, active low) leaves the receiver outside a frame,
// both pipeline registers empty and the markers at 0x02 (start) and 0x03 (end).
`timescale 1ns / 1ps
`default_nettype none

module framed_packet_receiver_crc16 (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fpr_byte_if.sink     rx_i,
  fpr_cfg_if.sink      cfg_i,
  fpr_result_if.source res_o
);
  import fpr_pkg::*;

  // Byte register: holds the accepted request until the parser consumes it.
  logic  byte_vld_q;
  byte_t byte_q;

  // Result register: decouples the parser from a stalled consumer.
  logic        res_vld_q;
  fpr_result_t res_q;

  fpr_markers_t markers;
  logic         advance;
  logic         step;
  logic         emit;
  logic         res_load;
  fpr_result_t  result;

  fpr_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .markers_o (markers)
  );

  // The parser may consume the held byte whenever the result register is
  // free or is being emptied in this cycle, so a stream of bytes flows at
  // one per cycle while the consumer keeps ready high.
  assign advance  = !res_vld_q || res_o.ready;
  assign step     = byte_vld_q && advance;
  assign res_load = step && emit;

  assign rx_i.ready = !byte_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      byte_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  fpr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (byte_q),
    .markers_i (markers),
    .emit_o    (emit),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_load) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= result;
    end
  end

  assign res_o.valid              = res_vld_q;
  assign res_o.frame_status       = res_q.frame_status;
  assign res_o.message_type       = res_q.message_type;
  assign res_o.payload_length     = res_q.payload_length;
  assign res_o.received_crc       = res_q.received_crc;
  assign res_o.computed_crc       = res_q.computed_crc;
  assign res_o.first_payload_byte = res_q.first_payload_byte;

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!res_vld_q || res_o.ready))
    else $error("result register overwritten while still pending");

  // A frame reported as valid must carry matching CRCs.
  a_valid_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && result.frame_status == ST_VALID)
      |-> (result.received_crc == result.computed_crc))
    else $error("valid verdict with mismatching CRC");

  // A byte held back by a stalled result register stays in place.
  a_byte_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_vld_q && !advance) |=> (byte_vld_q && $stable(byte_q)))
    else $error("held byte lost while parser stalled");

endmodule

`default_nettype wire

### tb/tb_framed_packet_receiver_crc16.sv
`timescale 1ns / 1ps

module tb_framed_packet_receiver_crc16;
  import fpr_pkg::*;

  // Cycles allowed after the last verdict before a register write or the end.
  // A result passes through only the byte and result registers, so this is ample.
  localparam int unsigned SettleCycles = 8;
  // The slowest run carries roughly 800 bytes, each possibly waiting out a
  // sender gap and a stalled result register; this bound is far above that.
  localparam int unsigned CycleLimit = 300000;
  // Random frame bytes queued per phase; overflow frames and noise are extra.
  localparam int unsigned PhaseBudget = 50;
  // An index past the end of the register list; writes to it must be ignored.
  localparam cfg_idx_t CfgUnusedIdx = cfg_idx_t'(9);

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SINK,
    IDLE_BOTH
  } idle_mode_e;

  typedef enum logic [2:0] {
    FRM_GOOD,
    FRM_BAD_CRC,
    FRM_BAD_LEN,
    FRM_SHORT,
    FRM_OVERFLOW
  } frame_kind_e;

  // Receiver state as the byte stream leaves it.
  typedef struct {
    logic  open;
    byte_t count;
    byte_t msg_type;
    word_t length;
    word_t rx_crc;
    word_t run_crc;
    byte_t first;
  } frame_state_t;

  logic clk_i;
  logic rst_ni;

  fpr_byte_if   rx_if ();
  fpr_cfg_if    cfg_if ();
  fpr_result_if res_if ();

  framed_packet_receiver_crc16 dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  // Bytes still to be offered on the link; the head is the one on the wires
  // while rx_holding is set.
  byte_t        link_bytes[$];
  logic         rx_holding;
  // Verdicts the receiver owes, oldest first.
  fpr_result_t  verdicts_due[$];
  // Markers the receiver holds (tracked from accepted writes) and the
  // markers the frame builder is currently using.
  fpr_markers_t live_mk;
  fpr_markers_t gen_mk;
  frame_state_t frm;
  idle_mode_e   idle_mode;
  int unsigned  error_count;
  int unsigned  cycle_count;
  int unsigned  spare_overflows;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // CRC-16-CCITT, MSB first: one feedback bit per input bit.
  function automatic word_t crc_step(input word_t crc, input byte_t b);
    word_t c;
    logic  fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  function automatic fpr_result_t frame_verdict(input fpr_status_e st);
    fpr_result_t r;
    r.frame_status       = st;
    r.message_type       = frm.msg_type;
    r.payload_length     = frm.length;
    r.received_crc       = frm.rx_crc;
    r.computed_crc       = frm.run_crc;
    r.first_payload_byte = frm.first;
    return r;
  endfunction

  // Moves the frame state forward by one accepted byte and queues the verdict
  // that the byte causes, if any.
  function automatic void advance_frame(input byte_t b);
    byte_t       pos;
    fpr_status_e st;
    if (!frm.open) begin
      // Outside a frame only the start marker matters; it opens a fresh frame.
      if (b == live_mk.start_marker) begin
        frm.open     = 1'b1;
        frm.count    = 8'd1;
        frm.msg_type = '0;
        frm.length   = '0;
        frm.rx_crc   = '0;
        frm.run_crc  = CrcInit;
        frm.first    = '0;
      end
      return;
    end
    // A byte beyond the frame size is dropped and the frame is given up.
    if (frm.count >= FrameBytes) begin
      frm.open = 1'b0;
      verdicts_due.push_back(frame_verdict(ST_OVERFLOW));
      return;
    end
    pos = frm.count;
    frm.count = frm.count + 8'd1;
    // Header bytes land in their fields even when they also close the frame.
    case (pos)
      OffType:  frm.msg_type      = b;
      OffLenHi: frm.length[15:8]  = b;
      OffLenLo: frm.length[7:0]   = b;
      OffCrcHi: frm.rx_crc[15:8]  = b;
      OffCrcLo: frm.rx_crc[7:0]   = b;
      default: ;
    endcase
    if (b == live_mk.end_marker) begin
      frm.open = 1'b0;
      // The total count includes both markers, hence the extra one.
      if (frm.count < HeaderBytes) begin
        st = ST_TOO_SHORT;
      end else if (int'(frm.count) != int'(HeaderBytes) + int'(frm.length) + 1) begin
        st = ST_LEN_MISMATCH;
      end else if (frm.rx_crc != frm.run_crc) begin
        st = ST_CRC_MISMATCH;
      end else begin
        st = ST_VALID;
      end
      verdicts_due.push_back(frame_verdict(st));
      return;
    end
    if (pos >= HeaderBytes) begin
      if (pos == HeaderBytes) begin
        frm.first = b;
      end
      frm.run_crc = crc_step(frm.run_crc, b);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    end
  endtask

  // The monitor works on the rising edge. It tracks register writes, feeds
  // every accepted byte request to the predictor and compares every accepted
  // verdict with the oldest one owed.
  always @(posedge clk_i) begin : monitor
    fpr_result_t want;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CfgStartMarker: live_mk.start_marker = cfg_if.data;
          CfgEndMarker:   live_mk.end_marker   = cfg_if.data;
          default: ;
        endcase
      end
      if (rx_if.valid && rx_if.ready) begin
        advance_frame(rx_if.rx_byte);
        link_bytes.delete(0);
        rx_holding = 1'b0;
      end
      if (res_if.valid && res_if.ready) begin
        if (verdicts_due.size() == 0) begin
          flag_mismatch($sformatf("verdict with nothing owed, status %0d",
                                  res_if.frame_status));
        end else begin
          want = verdicts_due.pop_front();
          check_field("frame_status", 16'(res_if.frame_status),
                      16'(want.frame_status));
          check_field("message_type", 16'(res_if.message_type),
                      16'(want.message_type));
          check_field("payload_length", res_if.payload_length, want.payload_length);
          check_field("received_crc", res_if.received_crc, want.received_crc);
          check_field("computed_crc", res_if.computed_crc, want.computed_crc);
          check_field("first_payload_byte", 16'(res_if.first_payload_byte),
                      16'(want.first_payload_byte));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  function automatic logic sender_rests();
    case (idle_mode)
      IDLE_SRC:  return $urandom_range(0, 99) < 62;
      IDLE_BOTH: return $urandom_range(0, 99) < 13;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic logic sink_stalls();
    case (idle_mode)
      IDLE_SINK: return $urandom_range(0, 99) < 62;
      IDLE_BOTH: return $urandom_range(0, 99) < 13;
      default:   return 1'b0;
    endcase
  endfunction

  // The driver works on the falling edge. A byte once offered stays on the
  // wires until it is taken; otherwise the next byte goes out unless the
  // sender rests this cycle. The result ready is redrawn every cycle.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rx_if.valid  <= 1'b0;
      res_if.ready <= 1'b0;
    end else begin
      if (!rx_holding) begin
        if (link_bytes.size() != 0 && !sender_rests()) begin
          rx_if.valid   <= 1'b1;
          rx_if.rx_byte <= link_bytes[0];
          rx_holding = 1'b1;
        end else begin
          // The byte lines carry junk while nothing is offered.
          rx_if.valid   <= 1'b0;
          rx_if.rx_byte <= byte_t'($urandom_range(0, 255));
        end
      end
      res_if.ready <= !sink_stalls();
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Any byte that cannot close the frame under the current markers.
  function automatic byte_t data_byte();
    byte_t b;
    do begin
      b = byte_t'($urandom_range(0, 255));
    end while (b == gen_mk.end_marker);
    return b;
  endfunction

  // Queues one frame of the given kind. Well-formed frames carry a correct
  // length and CRC; the broken kinds flip one bit of one of them, cut the
  // frame short, or run on past the size limit.
  task automatic queue_frame(input frame_kind_e kind);
    byte_t       payload[$];
    byte_t       b;
    word_t       crc_field;
    word_t       len_field;
    int unsigned plen;
    if (kind == FRM_OVERFLOW) begin
      // Counting the start marker, the last of these bytes is the one dropped.
      link_bytes.push_back(gen_mk.start_marker);
      repeat (FrameBytes) link_bytes.push_back(data_byte());
      return;
    end
    if (kind == FRM_SHORT) begin
      link_bytes.push_back(gen_mk.start_marker);
      repeat ($urandom_range(0, 4)) link_bytes.push_back(data_byte());
      link_bytes.push_back(gen_mk.end_marker);
      return;
    end
    // Mostly short payloads, now and then a longer one.
    plen = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 60);
    crc_field = CrcInit;
    repeat (plen) begin
      b = data_byte();
      payload.push_back(b);
      crc_field = crc_step(crc_field, b);
    end
    len_field = word_t'(plen);
    if (kind == FRM_BAD_LEN) begin
      len_field = len_field ^ (word_t'(1) << $urandom_range(0, 15));
    end
    if (kind == FRM_BAD_CRC) begin
      crc_field = crc_field ^ (word_t'(1) << $urandom_range(0, 15));
    end
    // Length and CRC bytes may happen to equal the end marker; the frame then
    // closes early, which the predictor follows like any other stream.
    link_bytes.push_back(gen_mk.start_marker);
    link_bytes.push_back(data_byte());
    link_bytes.push_back(len_field[15:8]);
    link_bytes.push_back(len_field[7:0]);
    link_bytes.push_back(crc_field[15:8]);
    link_bytes.push_back(crc_field[7:0]);
    foreach (payload[i]) link_bytes.push_back(payload[i]);
    link_bytes.push_back(gen_mk.end_marker);
  endtask

  // Junk between frames; it avoids the start marker so that the frame which
  // follows still opens where it should.
  task automatic queue_noise();
    byte_t b;
    repeat ($urandom_range(1, 4)) begin
      do begin
        b = byte_t'($urandom_range(0, 255));
      end while (b == gen_mk.start_marker);
      link_bytes.push_back(b);
    end
  endtask

  task automatic queue_random(input int unsigned budget);
    int unsigned queued;
    int unsigned n0;
    int unsigned roll;
    queued = 0;
    while (queued < budget) begin
      n0 = link_bytes.size();
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        queue_frame(FRM_GOOD);
      end else if (roll < 70) begin
        queue_frame(FRM_BAD_CRC);
      end else if (roll < 80) begin
        queue_frame(FRM_BAD_LEN);
      end else if (roll < 90) begin
        queue_frame(FRM_SHORT);
      end else begin
        if (roll < 93 && spare_overflows != 0) begin
          spare_overflows--;
          queue_frame(FRM_OVERFLOW);
        end else begin
          queue_noise();
        end
        // Overflow frames and noise do not count against the budget.
        n0 = link_bytes.size();
      end
      queued += link_bytes.size() - n0;
    end
  endtask

  // The short directed opening, under the reset markers.
  task automatic queue_directed();
    word_t c;
    // An end marker outside a frame is ignored.
    link_bytes.push_back(EndMarkerRst);
    // Opened and closed at once: too short, the end marker lands in the type.
    link_bytes.push_back(StartMarkerRst);
    link_bytes.push_back(EndMarkerRst);
    // Empty payload with the all-ones CRC of nothing: a valid frame.
    link_bytes.push_back(StartMarkerRst);
    link_bytes.push_back(8'hFF);
    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'h00);
    link_bytes.push_back(CrcInit[15:8]);
    link_bytes.push_back(CrcInit[7:0]);
    link_bytes.push_back(EndMarkerRst);
    // One payload byte equal to the start marker, which is plain data here.
    c = crc_step(CrcInit, StartMarkerRst);
    link_bytes.push_back(StartMarkerRst);
    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'h01);
    link_bytes.push_back(c[15:8]);
    link_bytes.push_back(c[7:0]);
    link_bytes.push_back(StartMarkerRst);
    link_bytes.push_back(EndMarkerRst);
    // Header cut short: the low length byte is the end marker.
    link_bytes.push_back(StartMarkerRst);
    link_bytes.push_back(8'h10);
    link_bytes.push_back(8'h00);
    link_bytes.push_back(EndMarkerRst);
    // Six bytes in all, closed by the low CRC byte: long enough, wrong length.
    link_bytes.push_back(StartMarkerRst);
    link_bytes.push_back(8'h01);
    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'hFF);
    link_bytes.push_back(EndMarkerRst);
  endtask

  // Waits until every byte has been taken and every verdict has come back,
  // then lets the pipeline settle in case a frame is still open inside it.
  task automatic wait_drained();
    while (link_bytes.size() != 0 || rx_holding || verdicts_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input byte_t val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do begin
      @(posedge clk_i);
    end while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // One phase: the link drains first so that the markers change only while
  // the block is idle, then a fresh batch of random frames goes out. The
  // write to an unused index comes after the real ones so that any effect on
  // a real register would show in the frames of this phase.
  task automatic run_phase(input byte_t start_mk, input byte_t end_mk,
                           input idle_mode_e mode, input logic with_overflow);
    wait_drained();
    write_reg(CfgStartMarker, start_mk);
    write_reg(CfgEndMarker, end_mk);
    write_reg(CfgUnusedIdx, 8'h55);
    gen_mk.start_marker = start_mk;
    gen_mk.end_marker   = end_mk;
    idle_mode = mode;
    if (with_overflow) begin
      queue_frame(FRM_OVERFLOW);
    end
    queue_random(PhaseBudget);
  endtask

  initial begin
    byte_t mk_a;
    byte_t mk_b;
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CfgStartMarker;
    cfg_if.data   = '0;
    res_if.ready  = 1'b0;
    rx_holding    = 1'b0;
    live_mk.start_marker = StartMarkerRst;
    live_mk.end_marker   = EndMarkerRst;
    gen_mk          = live_mk;
    frm.open        = 1'b0;
    frm.count       = '0;
    frm.msg_type    = '0;
    frm.length      = '0;
    frm.rx_crc      = '0;
    frm.run_crc     = CrcInit;
    frm.first       = '0;
    idle_mode       = IDLE_NONE;
    error_count     = 0;
    cycle_count     = 0;
    spare_overflows = 1;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset markers, no idling: the directed opening, a frame that runs over
    // the size limit, then random frames.
    queue_directed();
    queue_frame(FRM_OVERFLOW);
    queue_random(PhaseBudget);

    // Lowest start marker and highest end marker, sender resting often.
    run_phase(8'h00, 8'hFF, IDLE_SRC, 1'b0);

    // The other way round, result side stalling often. With a zero end
    // marker the high length byte closes every frame whose length field is below 256.
    run_phase(8'hFF, 8'h00, IDLE_SINK, 1'b0);

    // Equal markers: the byte opens a frame outside one and closes it inside.
    run_phase(8'h7E, 8'h7E, IDLE_BOTH, 1'b1);

    mk_a = byte_t'($urandom_range(0, 255));
    mk_b = byte_t'($urandom_range(0, 255));
    run_phase(mk_a, mk_b, IDLE_SINK, 1'b0);

    // Back to the reset values, with both sides idling now and then.
    run_phase(StartMarkerRst, EndMarkerRst, IDLE_BOTH, 1'b0);

    wait_drained();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
